// ===== src/ata_pio_transfer_sequencer_unit_defines.svh =====
// Assertion macros shared by the checker of the ATA PIO sequencer.
// No dependencies.
`ifndef ATA_PIO_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH
`define ATA_PIO_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define APS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication checked on the next clock edge outside reset
`define APS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/aps_pkg.sv =====
// Types, codes and constants of the ATA PIO sequencer.
// No dependencies.
package aps_pkg;
   localparam int WORDS_PER_SECTOR = 256;
   localparam logic [16:0] POLL_LIMIT_RESET = 17'd100000;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   typedef enum logic [1:0] {REQ_READ, REQ_WRITE, REQ_STATUS, REQ_DATA} req_kind_type;
   typedef enum logic [2:0] {
      K_BWR, K_BRD, K_WRD, K_WWR, K_HOST, K_DONE
   } access_kind_type;
   typedef enum logic [2:0] {
      OC_PENDING, OC_SUCCESS, OC_DEVERR, OC_TIMEOUT, OC_RANGE, OC_REJECT
   } outcome_type;
   typedef enum logic [1:0] {PH_IDLE, PH_POLL, PH_DATA, PH_FLUSH} phase_type;
   typedef enum logic [2:0] {
      CSR_CMD_BASE, CSR_CTL_BASE, CSR_SLAVE, CSR_LBA48, CSR_POLL_LIMIT
   } csr_index_type;

   // work codes handed from the front part to the back part
   typedef enum logic [3:0] {
      OP_REJECT, OP_DONE_OK, OP_DONE_RANGE, OP_DONE_ERR, OP_DONE_TIMEOUT,
      OP_START48, OP_START28, OP_FLUSH, OP_POLL_AGAIN, OP_FLUSH_POLL,
      OP_WORD_REQ, OP_WORD_SECT, OP_WORD_FLUSH, OP_WORD_DONE
   } op_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [31:0] lba;
      logic [7:0] sector_count;
      logic [7:0] status_byte;
      logic [15:0] data_word;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] access_kind;
      logic [15:0] port_address;
      logic [15:0] out_value;
      logic [15:0] buffer_index;
      logic [2:0] outcome;
      logic last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] command_base;
      logic [15:0] control_base;
      logic is_slave;
      logic lba48;
      logic [16:0] poll_limit;
   } cfg_type;

   // one classified item
   typedef struct packed {
      op_type op;
      logic writing;
      logic [31:0] lba;
      logic [7:0] count;
      logic [15:0] word;
      logic [15:0] index;
   } work_type;
endpackage

// ===== src/ata_pio_transfer_sequencer_unit.sv =====
// Top level of the ATA PIO sequencer: register port, front, queue, back.
// Depends on aps_pkg, aps_front, aps_queue, aps_back.
//   channel | direction | handshake       | payload
//   req_    | in        | valid / stall   | req_payload_type
//   rsp_    | out       | valid / stall   | rsp_payload_type
//   csr_    | in        | APB-style write | 32-bit registers at 4*i
// A request is accepted while the work queue has room.
// The back part sends one bus access per cycle while the output is not stalled;
// a request yields 1 to 17 results: a status hit yields 1, a data word 2,
// or 3 when the flush follows and 6 at the end of a sector.
// Reset is synchronous; rsp_stall holds the output register and the queue
// fills behind it, then req_stall rises.
module ata_pio_transfer_sequencer_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  aps_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output aps_pkg::rsp_payload_type rsp_payload,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   aps_pkg::cfg_type cfg_ff;
   aps_pkg::work_type fwork, qhead, bwork;
   logic fvalid, qfull, qvalid, qpop;
   aps_pkg::csr_index_type ridx;
   logic [2:0] ridx_raw;

   assign pready = 1'b1;
   assign ridx_raw = paddr[4:2];
   assign ridx = aps_pkg::csr_index_type'(ridx_raw);

   always_comb begin
      unique case (ridx)
         aps_pkg::CSR_CMD_BASE: prdata = {16'd0, cfg_ff.command_base};
         aps_pkg::CSR_CTL_BASE: prdata = {16'd0, cfg_ff.control_base};
         aps_pkg::CSR_SLAVE: prdata = {31'd0, cfg_ff.is_slave};
         aps_pkg::CSR_LBA48: prdata = {31'd0, cfg_ff.lba48};
         aps_pkg::CSR_POLL_LIMIT: prdata = {15'd0, cfg_ff.poll_limit};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_base <= 16'h01F0;
         cfg_ff.control_base <= 16'h03F6;
         cfg_ff.is_slave <= 1'b0;
         cfg_ff.lba48 <= 1'b0;
         cfg_ff.poll_limit <= aps_pkg::POLL_LIMIT_RESET;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         case (ridx)
            aps_pkg::CSR_CMD_BASE: cfg_ff.command_base <= pwdata[15:0];
            aps_pkg::CSR_CTL_BASE: cfg_ff.control_base <= pwdata[15:0];
            aps_pkg::CSR_SLAVE: cfg_ff.is_slave <= pwdata[0];
            aps_pkg::CSR_LBA48: cfg_ff.lba48 <= pwdata[0];
            aps_pkg::CSR_POLL_LIMIT: cfg_ff.poll_limit <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   // tag word items: count[0] marks a data-word transfer ahead of a request
   always_comb begin
      bwork = fwork;
      bwork.count[0] = (req_payload.req_type == 2'(aps_pkg::REQ_DATA)) ? 1'b1 :
         (fwork.op == aps_pkg::OP_WORD_REQ ? 1'b0 : fwork.count[0]);
   end

   aps_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req_valid(req_valid),
      .req_stall(req_stall), .req_payload(req_payload), .work_valid(fvalid),
      .work_full(qfull), .work(fwork)
   );

   aps_queue u_queue (
      .clock(clock), .reset(reset), .push(fvalid), .push_data(bwork), .full(qfull),
      .head_valid(qvalid), .pop(qpop), .head(qhead)
   );

   aps_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .work_valid(qvalid), .work(qhead),
      .work_pop(qpop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );
endmodule

// ===== src/aps_ram.sv =====
// Generic single write, single registered read RAM.
// No dependencies.
module aps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/aps_front.sv =====
// Front part: accepts requests, updates the sequencing state, classifies work.
// Depends on aps_pkg.
module aps_front (
   input  logic clock,
   input  logic reset,
   input  aps_pkg::cfg_type cfg,
   input  logic req_valid,
   output logic req_stall,
   input  aps_pkg::req_payload_type req_payload,
   output logic work_valid,
   input  logic work_full,
   output aps_pkg::work_type work
);
   aps_pkg::phase_type phase_ff, phase_in;
   logic writing_ff, writing_in;
   logic [7:0] left_ff, left_in;
   logic [8:0] wcnt_ff, wcnt_in;
   logic [16:0] poll_ff, poll_in;
   logic [15:0] hidx_ff, hidx_in;
   logic go;
   logic [7:0] st;
   logic [8:0] wnext;

   assign req_stall = work_full;
   assign go = req_valid && !work_full;
   assign work_valid = go;
   assign st = req_payload.status_byte;
   assign wnext = wcnt_ff + 9'd1;

   always_comb begin
      phase_in = phase_ff;
      writing_in = writing_ff;
      left_in = left_ff;
      wcnt_in = wcnt_ff;
      poll_in = poll_ff;
      hidx_in = hidx_ff;
      work.op = aps_pkg::OP_REJECT;
      work.writing = writing_ff;
      work.lba = req_payload.lba;
      work.count = req_payload.sector_count;
      work.word = req_payload.data_word;
      work.index = hidx_ff;
      unique case (aps_pkg::req_kind_type'(req_payload.req_type))
         aps_pkg::REQ_READ, aps_pkg::REQ_WRITE: begin
            if (phase_ff == aps_pkg::PH_IDLE) begin
               writing_in = req_payload.req_type[0];
               work.writing = req_payload.req_type[0];
               left_in = req_payload.sector_count;
               wcnt_in = '0;
               hidx_in = '0;
               poll_in = '0;
               if (req_payload.sector_count == 8'd0) begin
                  if (req_payload.req_type[0]) begin
                     work.op = aps_pkg::OP_FLUSH;
                     phase_in = aps_pkg::PH_FLUSH;
                  end else begin
                     work.op = aps_pkg::OP_DONE_OK;
                  end
               end else if (cfg.lba48) begin
                  work.op = aps_pkg::OP_START48;
                  phase_in = aps_pkg::PH_POLL;
                  poll_in = 17'd1;
               end else if (req_payload.lba[31:28] != 4'd0) begin
                  work.op = aps_pkg::OP_DONE_RANGE;
               end else begin
                  work.op = aps_pkg::OP_START28;
                  phase_in = aps_pkg::PH_POLL;
                  poll_in = 17'd1;
               end
            end
         end
         aps_pkg::REQ_STATUS: begin
            if (phase_ff == aps_pkg::PH_POLL) begin
               if (st[0] || st[5]) begin
                  work.op = aps_pkg::OP_DONE_ERR;
                  phase_in = aps_pkg::PH_IDLE;
               end else if (!st[7] && st[3]) begin
                  work.op = aps_pkg::OP_WORD_REQ;
                  phase_in = aps_pkg::PH_DATA;
                  wcnt_in = '0;
               end else if (poll_ff >= cfg.poll_limit) begin
                  work.op = aps_pkg::OP_DONE_TIMEOUT;
                  phase_in = aps_pkg::PH_IDLE;
               end else begin
                  work.op = aps_pkg::OP_POLL_AGAIN;
                  poll_in = poll_ff + 17'd1;
               end
            end else if (phase_ff == aps_pkg::PH_FLUSH) begin
               if (st[7]) begin
                  work.op = aps_pkg::OP_FLUSH_POLL;
               end else begin
                  work.op = aps_pkg::OP_DONE_OK;
                  phase_in = aps_pkg::PH_IDLE;
               end
            end
         end
         aps_pkg::REQ_DATA: begin
            if (phase_ff == aps_pkg::PH_DATA) begin
               hidx_in = hidx_ff + 16'd1;
               if (wnext < 9'(aps_pkg::WORDS_PER_SECTOR)) begin
                  wcnt_in = wnext;
                  work.op = aps_pkg::OP_WORD_REQ;
               end else begin
                  wcnt_in = '0;
                  left_in = left_ff - 8'd1;
                  if (left_ff != 8'd1) begin
                     work.op = aps_pkg::OP_WORD_SECT;
                     phase_in = aps_pkg::PH_POLL;
                     poll_in = 17'd1;
                  end else if (writing_ff) begin
                     work.op = aps_pkg::OP_WORD_FLUSH;
                     phase_in = aps_pkg::PH_FLUSH;
                  end else begin
                     work.op = aps_pkg::OP_WORD_DONE;
                     phase_in = aps_pkg::PH_IDLE;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= aps_pkg::PH_IDLE;
         writing_ff <= 1'b0;
         left_ff <= '0;
         wcnt_ff <= '0;
         poll_ff <= '0;
         hidx_ff <= '0;
      end else if (go) begin
         phase_ff <= phase_in;
         writing_ff <= writing_in;
         left_ff <= left_in;
         wcnt_ff <= wcnt_in;
         poll_ff <= poll_in;
         hidx_ff <= hidx_in;
      end
   end
endmodule

// ===== src/aps_queue.sv =====
// Short queue of classified work between the front and back parts.
// Depends on aps_pkg and aps_ram.
module aps_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  aps_pkg::work_type push_data,
   output logic full,
   output logic head_valid,
   input  logic pop,
   output aps_pkg::work_type head
);
   localparam int W = $bits(aps_pkg::work_type);
   logic [aps_pkg::QUEUE_AW-1:0] wp_ff, rp_ff, rp_next;
   logic [aps_pkg::QUEUE_AW-1:0] rd_addr;
   logic [aps_pkg::QUEUE_AW:0] cnt_ff, cnt_in;
   logic [aps_pkg::QUEUE_AW:0] shown_ff, shown_in;
   logic [W-1:0] rd_data;
   logic fetch;

   // the RAM read is registered: a fetched entry appears in the cycle after the fetch
   assign head = aps_pkg::work_type'(rd_data);
   assign full = cnt_ff >= (aps_pkg::QUEUE_AW+1)'(aps_pkg::QUEUE_DEPTH - 1);
   assign head_valid = shown_ff[0];
   assign fetch = (cnt_ff != '0) && (!shown_ff[0] || pop) && !(shown_ff[1]);
   assign rp_next = fetch ? rp_ff + 1'b1 : rp_ff;
   // keep rereading the shown entry until the next one is fetched
   assign rd_addr = fetch ? rp_ff : rp_ff - 1'b1;

   aps_ram #(.WIDTH(W), .DEPTH(aps_pkg::QUEUE_DEPTH)) u_ram (
      .clock(clock), .wr_en(push), .wr_addr(wp_ff), .wr_data(W'(push_data)),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (fetch ? 1'b1 : 1'b0);
      shown_in = {1'b0, fetch || (shown_ff[0] && !pop)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         shown_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         rp_ff <= rp_next;
         cnt_ff <= cnt_in;
         shown_ff <= shown_in;
      end
   end
endmodule

// ===== src/aps_back.sv =====
// Back part: expands each classified work item into its bus accesses.
// Depends on aps_pkg.
module aps_back (
   input  logic clock,
   input  logic reset,
   input  aps_pkg::cfg_type cfg,
   input  logic work_valid,
   input  aps_pkg::work_type work,
   output logic work_pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output aps_pkg::rsp_payload_type rsp_payload
);
   logic [4:0] step_ff, step_in;
   logic [4:0] last_step;
   logic out_free;
   logic emit;
   aps_pkg::rsp_payload_type r;
   logic [15:0] cb;
   logic [7:0] bval;
   logic [2:0] boff;
   logic vld_ff;
   aps_pkg::rsp_payload_type pay_ff;

   assign cb = cfg.command_base;
   assign out_free = !vld_ff || !rsp_stall;
   assign emit = work_valid && out_free;
   assign work_pop = emit && (step_ff == last_step);
   assign rsp_valid = vld_ff;
   assign rsp_payload = pay_ff;

   // count of accesses minus one for each work code
   always_comb begin
      case (work.op)
         aps_pkg::OP_START48: last_step = 5'd16;
         aps_pkg::OP_START28: last_step = 5'd11;
         aps_pkg::OP_FLUSH, aps_pkg::OP_FLUSH_POLL: last_step = 5'd1;
         aps_pkg::OP_WORD_REQ: last_step = {4'd0, work.count[0]};
         aps_pkg::OP_WORD_SECT: last_step = 5'd5;
         aps_pkg::OP_WORD_FLUSH: last_step = 5'd2;
         aps_pkg::OP_WORD_DONE: last_step = 5'd1;
         default: last_step = 5'd0;
      endcase
      if (work.op == aps_pkg::OP_FLUSH_POLL || work.op == aps_pkg::OP_POLL_AGAIN) begin
         last_step = 5'd0;
      end
   end

   always_comb begin
      boff = 3'd0;
      bval = 8'd0;
      if (work.op == aps_pkg::OP_START48) begin
         case (step_ff)
            5'd0: begin boff = 3'd6; bval = cfg.is_slave ? 8'h50 : 8'h40; end
            5'd1: boff = 3'd1;
            5'd2: boff = 3'd2;
            5'd3: begin boff = 3'd3; bval = work.lba[31:24]; end
            5'd4: boff = 3'd4;
            5'd5: boff = 3'd5;
            5'd6: boff = 3'd1;
            5'd7: begin boff = 3'd2; bval = work.count; end
            5'd8: begin boff = 3'd3; bval = work.lba[7:0]; end
            5'd9: begin boff = 3'd4; bval = work.lba[15:8]; end
            5'd10: begin boff = 3'd5; bval = work.lba[23:16]; end
            default: begin boff = 3'd7; bval = work.writing ? 8'h34 : 8'h24; end
         endcase
      end else begin
         case (step_ff)
            5'd0: boff = 3'd1;
            5'd1: begin boff = 3'd2; bval = work.count; end
            5'd2: begin boff = 3'd3; bval = work.lba[7:0]; end
            5'd3: begin boff = 3'd4; bval = work.lba[15:8]; end
            5'd4: begin boff = 3'd5; bval = work.lba[23:16]; end
            5'd5: begin
               boff = 3'd6;
               bval = (cfg.is_slave ? 8'hF0 : 8'hE0) | {4'd0, work.lba[27:24]};
            end
            default: begin boff = 3'd7; bval = work.writing ? 8'h30 : 8'h20; end
         endcase
      end
   end

   always_comb begin
      r = '0;
      r.last_of_run = (step_ff == last_step);
      unique case (work.op)
         aps_pkg::OP_REJECT: begin
            r.access_kind = aps_pkg::K_DONE;
            r.outcome = aps_pkg::OC_REJECT;
         end
         aps_pkg::OP_DONE_OK, aps_pkg::OP_DONE_RANGE, aps_pkg::OP_DONE_ERR,
         aps_pkg::OP_DONE_TIMEOUT: begin
            r.access_kind = aps_pkg::K_DONE;
            case (work.op)
               aps_pkg::OP_DONE_OK: r.outcome = aps_pkg::OC_SUCCESS;
               aps_pkg::OP_DONE_RANGE: r.outcome = aps_pkg::OC_RANGE;
               aps_pkg::OP_DONE_ERR: r.outcome = aps_pkg::OC_DEVERR;
               default: r.outcome = aps_pkg::OC_TIMEOUT;
            endcase
         end
         aps_pkg::OP_START48, aps_pkg::OP_START28: begin
            if ((work.op == aps_pkg::OP_START48 && step_ff < 5'd12) ||
                (work.op == aps_pkg::OP_START28 && step_ff < 5'd7)) begin
               r.access_kind = aps_pkg::K_BWR;
               r.port_address = cb + {13'd0, boff};
               r.out_value = {8'd0, bval};
            end else begin
               r.access_kind = aps_pkg::K_BRD;
               r.port_address = cfg.control_base;
            end
         end
         aps_pkg::OP_POLL_AGAIN: begin
            r.access_kind = aps_pkg::K_BRD;
            r.port_address = cfg.control_base;
         end
         aps_pkg::OP_FLUSH, aps_pkg::OP_FLUSH_POLL: begin
            if (work.op == aps_pkg::OP_FLUSH && step_ff == 5'd0) begin
               r.access_kind = aps_pkg::K_BWR;
               r.port_address = cb + 16'd7;
               r.out_value = cfg.lba48 ? 16'h00EA : 16'h00E7;
            end else begin
               r.access_kind = aps_pkg::K_BRD;
               r.port_address = cb + 16'd7;
            end
         end
         default: begin
            // data phase: a word access, then what follows it
            if (step_ff == 5'd0 && work.op != aps_pkg::OP_WORD_REQ) begin
               r.buffer_index = work.index;
               if (work.writing) begin
                  r.access_kind = aps_pkg::K_WWR;
                  r.port_address = cb;
                  r.out_value = work.word;
               end else begin
                  r.access_kind = aps_pkg::K_HOST;
                  r.out_value = work.word;
               end
            end else if (work.op == aps_pkg::OP_WORD_REQ) begin
               // word_req item: for a status hit step 0 only; for a data word
               // step 0 is the transfer, step 1 the next request
               if (step_ff == 5'd0 && work.count[0]) begin
                  r.buffer_index = work.index;
                  if (work.writing) begin
                     r.access_kind = aps_pkg::K_WWR;
                     r.port_address = cb;
                     r.out_value = work.word;
                  end else begin
                     r.access_kind = aps_pkg::K_HOST;
                     r.out_value = work.word;
                  end
               end else begin
                  r.buffer_index = work.count[0] ? work.index + 16'd1 : work.index;
                  if (work.writing) begin
                     r.access_kind = aps_pkg::K_HOST;
                  end else begin
                     r.access_kind = aps_pkg::K_WRD;
                     r.port_address = cb;
                  end
               end
            end else if (work.op == aps_pkg::OP_WORD_SECT) begin
               r.access_kind = aps_pkg::K_BRD;
               r.port_address = cfg.control_base;
            end else if (work.op == aps_pkg::OP_WORD_FLUSH) begin
               r.port_address = cb + 16'd7;
               if (step_ff == 5'd1) begin
                  r.access_kind = aps_pkg::K_BWR;
                  r.out_value = cfg.lba48 ? 16'h00EA : 16'h00E7;
               end else begin
                  r.access_kind = aps_pkg::K_BRD;
               end
            end else begin
               r.access_kind = aps_pkg::K_DONE;
               r.outcome = aps_pkg::OC_SUCCESS;
            end
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = (step_ff == last_step) ? 5'd0 : step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (out_free) begin
            vld_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pay_ff <= r;
      end
   end
endmodule

// ===== src/aps_checker.sv =====
// Port-level checker of the ATA PIO sequencer, bound to the top level.
// Depends on aps_pkg and ata_pio_transfer_sequencer_unit_defines.svh.
`include "ata_pio_transfer_sequencer_unit_defines.svh"
module aps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input aps_pkg::rsp_payload_type rsp_payload,
   input logic pready
);
   `APS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid)
   `APS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `APS_ASSERT_IMPL(a_outcome_done, clock, reset, rsp_valid && rsp_payload.outcome != 3'd0, rsp_payload.access_kind == 3'(aps_pkg::K_DONE) && rsp_payload.last_of_run)
   `APS_ASSERT_IMPL(a_done_last, clock, reset, rsp_valid && rsp_payload.access_kind == 3'(aps_pkg::K_DONE), rsp_payload.last_of_run)
   `APS_ASSERT_IMPL(a_pready, clock, reset, 1'b1, pready)
endmodule

bind ata_pio_transfer_sequencer_unit aps_checker u_aps_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
   .pready(pready)
);

// ===== test/ata_pio_transfer_sequencer_unit_tb.sv =====
// Self-checking testbench of the ATA PIO transfer sequencer: directed and random
// transfer sequences under several register settings, checked against a predictor.
// Depends on aps_pkg and ata_pio_transfer_sequencer_unit.

module testbench;
   import aps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class transfer_scoreboard;
      logic [15:0] cmd_base;
      logic [15:0] ctl_base;
      logic slave;
      logic lba48;
      logic [16:0] poll_limit;
      phase_type phase;
      logic writing;
      logic [7:0] sectors_left;
      logic [8:0] word_count;
      logic [16:0] poll_count;
      logic [15:0] host_index;
      rsp_payload_type burst[$];
      rsp_payload_type expected_accesses[$];
      int errors;

      function new();
         cmd_base = 16'h01F0;
         ctl_base = 16'h03F6;
         slave = 1'b0;
         lba48 = 1'b0;
         poll_limit = POLL_LIMIT_RESET;
         phase = PH_IDLE;
         writing = 1'b0;
         sectors_left = '0;
         word_count = '0;
         poll_count = '0;
         host_index = '0;
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_CMD_BASE: cmd_base = value[15:0];
            CSR_CTL_BASE: ctl_base = value[15:0];
            CSR_SLAVE: slave = value[0];
            CSR_LBA48: lba48 = value[0];
            CSR_POLL_LIMIT: poll_limit = value[16:0];
            default: ;
         endcase
      endfunction

      function void add(access_kind_type kind, logic [15:0] port, logic [15:0] value,
                        logic [15:0] idx, outcome_type oc);
         rsp_payload_type r;
         r.access_kind = kind;
         r.port_address = port;
         r.out_value = value;
         r.buffer_index = idx;
         r.outcome = oc;
         r.last_of_run = 1'b0;
         burst.push_back(r);
      endfunction

      function void task_file(logic [2:0] off, logic [7:0] value);
         add(K_BWR, cmd_base + 16'(off), {8'h00, value}, '0, OC_PENDING);
      endfunction

      function void finish(outcome_type oc);
         phase = PH_IDLE;
         add(K_DONE, '0, '0, '0, oc);
      endfunction

      function void begin_sector();
         repeat (5) add(K_BRD, ctl_base, '0, '0, OC_PENDING);
         phase = PH_POLL;
         poll_count = 17'd1;
      endfunction

      function void begin_flush();
         task_file(3'd7, lba48 ? 8'hEA : 8'hE7);
         add(K_BRD, cmd_base + 16'd7, '0, '0, OC_PENDING);
         phase = PH_FLUSH;
      endfunction

      function void word_request();
         if (writing) add(K_HOST, '0, '0, host_index, OC_PENDING);
         else add(K_WRD, cmd_base, '0, host_index, OC_PENDING);
      endfunction

      function void start_transfer(logic wr, logic [31:0] lba, logic [7:0] cnt);
         writing = wr;
         sectors_left = cnt;
         word_count = '0;
         host_index = '0;
         poll_count = '0;
         if (cnt == 8'd0) begin
            if (wr) begin_flush();
            else finish(OC_SUCCESS);
         end else if (lba48) begin
            task_file(3'd6, slave ? 8'h50 : 8'h40);
            task_file(3'd1, 8'h00);
            task_file(3'd2, 8'h00);
            task_file(3'd3, lba[31:24]);
            task_file(3'd4, 8'h00);
            task_file(3'd5, 8'h00);
            task_file(3'd1, 8'h00);
            task_file(3'd2, cnt);
            task_file(3'd3, lba[7:0]);
            task_file(3'd4, lba[15:8]);
            task_file(3'd5, lba[23:16]);
            task_file(3'd7, wr ? 8'h34 : 8'h24);
            begin_sector();
         end else if (lba >= 32'h1000_0000) begin
            finish(OC_RANGE);
         end else begin
            task_file(3'd1, 8'h00);
            task_file(3'd2, cnt);
            task_file(3'd3, lba[7:0]);
            task_file(3'd4, lba[15:8]);
            task_file(3'd5, lba[23:16]);
            task_file(3'd6, (slave ? 8'hF0 : 8'hE0) | {4'h0, lba[27:24]});
            task_file(3'd7, wr ? 8'h30 : 8'h20);
            begin_sector();
         end
      endfunction

      function void note_request(req_payload_type p);
         burst.delete();
         case (req_kind_type'(p.req_type))
            REQ_READ, REQ_WRITE: begin
               if (phase != PH_IDLE) add(K_DONE, '0, '0, '0, OC_REJECT);
               else start_transfer(p.req_type[0], p.lba, p.sector_count);
            end
            REQ_STATUS: begin
               if (phase == PH_POLL) begin
                  if (p.status_byte[0] || p.status_byte[5]) begin
                     finish(OC_DEVERR);
                  end else if (!p.status_byte[7] && p.status_byte[3]) begin
                     phase = PH_DATA;
                     word_count = '0;
                     word_request();
                  end else if (poll_count >= poll_limit) begin
                     finish(OC_TIMEOUT);
                  end else begin
                     poll_count = poll_count + 17'd1;
                     add(K_BRD, ctl_base, '0, '0, OC_PENDING);
                  end
               end else if (phase == PH_FLUSH) begin
                  if (p.status_byte[7]) add(K_BRD, cmd_base + 16'd7, '0, '0, OC_PENDING);
                  else finish(OC_SUCCESS);
               end else begin
                  add(K_DONE, '0, '0, '0, OC_REJECT);
               end
            end
            default: begin
               if (phase != PH_DATA) begin
                  add(K_DONE, '0, '0, '0, OC_REJECT);
               end else begin
                  if (writing) add(K_WWR, cmd_base, p.data_word, host_index, OC_PENDING);
                  else add(K_HOST, '0, p.data_word, host_index, OC_PENDING);
                  host_index = host_index + 16'd1;
                  word_count = word_count + 9'd1;
                  if (word_count < 9'(WORDS_PER_SECTOR)) begin
                     word_request();
                  end else begin
                     word_count = '0;
                     sectors_left = sectors_left - 8'd1;
                     if (sectors_left != 8'd0) begin_sector();
                     else if (writing) begin_flush();
                     else finish(OC_SUCCESS);
                  end
               end
            end
         endcase
         burst[burst.size() - 1].last_of_run = 1'b1;
         foreach (burst[i]) expected_accesses.push_back(burst[i]);
      endfunction

      function void check_access(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_accesses.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_accesses.pop_front();
         if (got.access_kind !== want.access_kind) begin
            $display("%0t: access_kind expected %0d actual %0d", $time,
                     want.access_kind, got.access_kind);
            errors++;
         end
         if (got.port_address !== want.port_address) begin
            $display("%0t: port_address expected %h actual %h", $time,
                     want.port_address, got.port_address);
            errors++;
         end
         if (got.out_value !== want.out_value) begin
            $display("%0t: out_value expected %h actual %h", $time,
                     want.out_value, got.out_value);
            errors++;
         end
         if (got.buffer_index !== want.buffer_index) begin
            $display("%0t: buffer_index expected %0d actual %0d", $time,
                     want.buffer_index, got.buffer_index);
            errors++;
         end
         if (got.outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time,
                     want.outcome, got.outcome);
            errors++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b actual %b", $time,
                     want.last_of_run, got.last_of_run);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 12;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [4:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   transfer_scoreboard sb = new();
   int item_count = 0;
   int tx_idle_pct = 12;
   int rx_idle_pct = 64;
   int cycle_count = 0;
   // a full sector is 256 items: allow only one data phase in the run
   bit data_allowed = 1'b1;

   ata_pio_transfer_sequencer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_access(rsp_payload);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_request(req_payload_type p);
      @(negedge clock);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = p;
      do @(posedge clock); while (req_stall);
      sb.note_request(p);
      if (sb.phase == PH_DATA) data_allowed = 1'b0;
      item_count++;
      // shift idling mode by progress through the stimulus
      if (item_count == 120) begin
         tx_idle_pct = 64;
         rx_idle_pct = 12;
      end else if (item_count == 240) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   function automatic req_payload_type make_req(req_kind_type kind, logic [31:0] lba,
                                                logic [7:0] cnt, logic [7:0] status,
                                                logic [15:0] word);
      req_payload_type p;
      p.req_type = kind;
      p.lba = lba;
      p.sector_count = cnt;
      p.status_byte = status;
      p.data_word = word;
      return p;
   endfunction

   function automatic req_payload_type rand_req(req_kind_type kind);
      return make_req(kind, $urandom, 8'($urandom), 8'($urandom), 16'($urandom));
   endfunction

   function automatic logic [7:0] poll_status();
      int r;
      logic [7:0] s;
      r = $urandom_range(99);
      s = 8'($urandom);
      if (r < 12) s = s | ($urandom_range(1) ? 8'h01 : 8'h20);
      else if (r < 45) s = (s & 8'hD6) | ($urandom_range(3) != 0 ? 8'h80 : 8'h00);
      else s = (s & 8'h5E) | 8'h08;
      return s;
   endfunction

   // walk the current transfer to its end with mostly well-formed traffic
   task automatic drive_until_idle();
      req_payload_type p;
      while (sb.phase != PH_IDLE) begin
         p = rand_req(REQ_STATUS);
         if ($urandom_range(99) < 3) begin
            p.req_type = 2'($urandom);
         end else if (sb.phase == PH_POLL) begin
            p.status_byte = poll_status();
         end else if (sb.phase == PH_DATA) begin
            p.req_type = REQ_DATA;
         end
         // turn a ready status into a device error once the data phase is used up
         if (sb.phase == PH_POLL && !data_allowed && p.status_byte[3] &&
             !p.status_byte[7]) begin
            p.status_byte[0] = 1'b1;
         end
         send_request(p);
      end
   endtask

   task automatic random_transfer();
      req_payload_type p;
      int r;
      r = $urandom_range(99);
      p = rand_req(req_kind_type'($urandom_range(1)));
      if (r < 10) p.req_type = $urandom_range(1) ? REQ_STATUS : REQ_DATA;
      else if (r < 25) p.sector_count = 8'd0;
      else if (r < 90) p.sector_count = 8'd1;
      else p.sector_count = 8'd2;
      if (!sb.lba48 && $urandom_range(99) < 80) p.lba[31:28] = 4'h0;
      send_request(p);
      drive_until_idle();
   endtask

   task automatic directed_transfers();
      send_request(make_req(REQ_READ, 32'h0, 8'd0, 8'h00, 16'h0));
      send_request(make_req(REQ_WRITE, 32'hFFFF_FFFF, 8'd0, 8'h00, 16'h0));
      send_request(make_req(REQ_STATUS, 32'h0, 8'd0, 8'hFF, 16'h0));
      send_request(make_req(REQ_STATUS, 32'h0, 8'd0, 8'h00, 16'h0));
      send_request(make_req(REQ_DATA, 32'h0, 8'd0, 8'h00, 16'hFFFF));
      send_request(make_req(REQ_READ, 32'h0FFF_FFFF, 8'd255, 8'h00, 16'h0));
      send_request(make_req(REQ_WRITE, 32'h0, 8'd1, 8'h00, 16'h0));
      send_request(make_req(REQ_STATUS, 32'h0, 8'd0, 8'h80, 16'h0));
      send_request(make_req(REQ_STATUS, 32'h0, 8'd0, 8'h01, 16'h0));
      if (sb.phase != PH_IDLE) drive_until_idle();
      send_request(make_req(REQ_WRITE, 32'h1000_0000, 8'd255, 8'h00, 16'h0));
      if (sb.phase != PH_IDLE) begin
         send_request(make_req(REQ_STATUS, 32'h0, 8'd0, 8'h00, 16'h0));
         if (sb.phase != PH_IDLE)
            send_request(make_req(REQ_STATUS, 32'h0, 8'd0, 8'h20, 16'h0));
      end
      if (sb.phase != PH_IDLE) drive_until_idle();
      send_request(make_req(REQ_READ, 32'hFFFF_FFFF, 8'd1, 8'h00, 16'h0));
      if (sb.phase != PH_IDLE) begin
         send_request(make_req(REQ_STATUS, 32'h0, 8'd0,
                               data_allowed ? (8'h7F & 8'hDE) : 8'h01, 16'h0));
         send_request(make_req(REQ_DATA, 32'h0, 8'd0, 8'h00, 16'h0000));
         send_request(make_req(REQ_DATA, 32'h0, 8'd0, 8'h00, 16'hFFFF));
         drive_until_idle();
      end
   endtask

   task automatic wait_idle();
      while (sb.expected_accesses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 5'(idx) << 2;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic configure(logic [15:0] cmd, logic [15:0] ctl, logic slv,
                            logic wide, logic [16:0] limit);
      csr_write(CSR_CMD_BASE, {16'h0, cmd});
      csr_write(CSR_CTL_BASE, {16'h0, ctl});
      csr_write(CSR_SLAVE, {31'h0, slv});
      csr_write(CSR_LBA48, {31'h0, wide});
      csr_write(CSR_POLL_LIMIT, {15'h0, limit});
   endtask

   task automatic run_phase(bit with_directed);
      int stop_at;
      if (with_directed) directed_transfers();
      stop_at = item_count + ITEMS_PER_PHASE;
      while (item_count < stop_at) random_transfer();
      @(negedge clock);
      req_valid = 1'b0;
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_phase(1'b1);
      configure(16'hFFFC, 16'hFFFF, 1'b1, 1'b1, 17'd1);
      run_phase(1'b1);
      configure(16'h0000, 16'h0000, 1'b0, 1'b0, 17'd3);
      run_phase(1'b1);
      configure(16'h01F0, 16'h03F6, 1'b1, 1'b0, 17'd131071);
      run_phase(1'b0);
      configure(16'($urandom), 16'($urandom), 1'b0, 1'b1, 17'($urandom_range(8, 1)));
      run_phase(1'b1);
      if (sb.errors == 0 && sb.expected_accesses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
